// ===== hw/rtl/pds_pkg.sv =====
`default_nettype none

package pds_pkg;

  localparam int unsigned MAX_PARTICLES = 64;

  localparam int unsigned IdW    = 10;
  localparam int unsigned CoordW = 20;
  localparam int unsigned LimitW = 36;
  localparam int unsigned DistW  = 44;
  localparam int unsigned AbsW   = CoordW + 1;
  localparam int unsigned SqW    = 2 * AbsW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LimitW-1:0] NearLimitReset = LimitW'(490000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CAMERA_X   = 2'd0,
    CFG_CAMERA_Y   = 2'd1,
    CFG_CAMERA_Z   = 2'd2,
    CFG_NEAR_LIMIT = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_FLUSH,
    ST_DRAIN
  } sort_state_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic             alive;
    logic [DistW-1:0] depth;
  } rec_t;

  // A record leaving the distance pipeline for the insertion chain.
  typedef struct packed {
    logic valid;
    logic store;
    logic last;
    rec_t rec;
  } ins_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic valid;
    logic push;
    rec_t rec;
  } link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pds_intf.sv =====
`default_nettype none

interface pds_in_if;
  logic                               valid;
  logic                               ready;
  logic [pds_pkg::IdW-1:0]            particle_id;
  logic                               exists;
  logic signed [pds_pkg::CoordW-1:0]  pos_x;
  logic signed [pds_pkg::CoordW-1:0]  pos_y;
  logic signed [pds_pkg::CoordW-1:0]  pos_z;
  logic                               last;

  modport source (output valid, particle_id, exists, pos_x, pos_y, pos_z, last,
                  input ready);
  modport sink (input valid, particle_id, exists, pos_x, pos_y, pos_z, last,
                output ready);
endinterface

interface pds_out_if;
  logic                         valid;
  logic                         ready;
  logic [pds_pkg::IdW-1:0]      out_id;
  logic                         out_exists;
  logic [pds_pkg::DistW-1:0]    distance;
  logic                         near;
  logic                         out_last;

  modport source (output valid, out_id, out_exists, distance, near, out_last,
                  input ready);
  modport sink (input valid, out_id, out_exists, distance, near, out_last,
                output ready);
endinterface

interface pds_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pds_pkg::CfgIdxW-1:0]   index;
  logic [pds_pkg::LimitW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pds_dist.sv =====
`default_nettype none

module pds_dist (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               valid_i,
  input  wire logic                               store_i,
  input  wire logic                               last_i,
  input  wire logic [pds_pkg::IdW-1:0]            id_i,
  input  wire logic                               alive_i,
  input  wire logic signed [pds_pkg::CoordW-1:0]  pos_x_i,
  input  wire logic signed [pds_pkg::CoordW-1:0]  pos_y_i,
  input  wire logic signed [pds_pkg::CoordW-1:0]  pos_z_i,
  input  wire logic signed [pds_pkg::CoordW-1:0]  cam_x_i,
  input  wire logic signed [pds_pkg::CoordW-1:0]  cam_y_i,
  input  wire logic signed [pds_pkg::CoordW-1:0]  cam_z_i,
  output pds_pkg::ins_t                           ins_o
);

  localparam int unsigned AbsW = pds_pkg::AbsW;
  localparam int unsigned SqW  = pds_pkg::SqW;

  logic [2:0] valid_q;
  logic [2:0] store_q, last_q;
  logic [pds_pkg::IdW-1:0] id1_q, id2_q, id3_q;
  logic [2:0] alive_q;
  logic [AbsW-1:0] ax_q, ay_q, az_q;
  logic [AbsW-1:0] ax_d, ay_d, az_d;
  logic [SqW-1:0] sx_q, sy_q, sz_q;
  logic [pds_pkg::DistW-1:0] dist_q;

  function automatic logic [AbsW-1:0] abs_diff(
    input logic signed [pds_pkg::CoordW-1:0] a,
    input logic signed [pds_pkg::CoordW-1:0] b
  );
    logic signed [AbsW-1:0] d;
    d = AbsW'(a) - AbsW'(b);
    return d[AbsW-1] ? AbsW'(-d) : AbsW'(d);
  endfunction

  assign ax_d = abs_diff(cam_x_i, pos_x_i);
  assign ay_d = abs_diff(cam_y_i, pos_y_i);
  assign az_d = abs_diff(cam_z_i, pos_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= {store_q[1:0], store_i};
    last_q  <= {last_q[1:0], last_i};
    alive_q <= {alive_q[1:0], alive_i};
    id1_q   <= id_i;
    id2_q   <= id1_q;
    id3_q   <= id2_q;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    az_q    <= az_d;
    sx_q    <= ax_q * ax_q;
    sy_q    <= ay_q * ay_q;
    sz_q    <= az_q * az_q;
    // The sum stays below 2^43, so the field maximum is never reached.
    dist_q  <= pds_pkg::DistW'(sx_q) + pds_pkg::DistW'(sy_q) + pds_pkg::DistW'(sz_q);
  end

  always_comb begin
    ins_o.valid     = valid_q[2];
    ins_o.store     = store_q[2];
    ins_o.last      = last_q[2];
    ins_o.rec.id    = id3_q;
    ins_o.rec.alive = alive_q[2];
    ins_o.rec.depth = dist_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pds_cell.sv =====
`default_nettype none

module pds_cell (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire pds_pkg::ins_t  ins_i,
  input  wire logic    shift_i,
  input  wire pds_pkg::link_t left_i,
  input  wire pds_pkg::link_t right_i,
  output pds_pkg::link_t link_o
);

  logic          valid_q, valid_d;
  pds_pkg::rec_t rec_q, rec_d;
  logic          push;

  // The new record goes behind every stored record that is at least as far.
  assign push = valid_q && (rec_q.depth < ins_i.rec.depth);

  always_comb begin
    valid_d = valid_q;
    rec_d   = rec_q;
    if (shift_i) begin
      valid_d = right_i.valid;
      rec_d   = right_i.rec;
    end else if (ins_i.valid && ins_i.store) begin
      if (left_i.push) begin
        valid_d = 1'b1;
        rec_d   = left_i.rec;
      end else if (left_i.valid && (push || !valid_q)) begin
        valid_d = 1'b1;
        rec_d   = ins_i.rec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_comb begin
    link_o.valid = valid_q;
    link_o.push  = push;
    link_o.rec   = rec_q;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/particle_depth_sort.sv =====
`default_nettype none

// Channel   Dir  Payload                                         Word accepted
// item_i    in   particle_id, exists, pos_x, pos_y, pos_z, last  valid && ready
// result_o  out  out_id, out_exists, distance, near, out_last    valid && ready
// cfg_i     in   index (register), data                          valid && ready
//
// Records load at one per cycle; each passes a three-stage distance pipeline and is
// then inserted into the cell chain, so the chain is always sorted. After a last
// record, item_i is held off until the set has drained. Results then leave the head
// cell at one per cycle while result_o is ready, and item_i takes a word again in
// the cycle after the last result leaves.
// A stall on result_o holds the chain. Reset empties the chain at once.
module particle_depth_sort #(
  parameter int unsigned MaxParticles = pds_pkg::MAX_PARTICLES
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pds_in_if.sink      item_i,
  pds_out_if.source   result_o,
  pds_cfg_if.sink     cfg_i
);

  localparam int unsigned CntW = $clog2(MaxParticles + 1);

  logic signed [pds_pkg::CoordW-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [pds_pkg::LimitW-1:0]        near_limit_q;
  logic [CntW-1:0]                   cnt_q;
  pds_pkg::sort_state_e              state_q, state_d;
  pds_pkg::ins_t                     ins;
  pds_pkg::link_t                    link [MaxParticles];
  logic                              in_acc, store, shift, tail_empty;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q      <= '0;
      cam_y_q      <= '0;
      cam_z_q      <= '0;
      near_limit_q <= pds_pkg::NearLimitReset;
    end else if (cfg_i.valid) begin
      case (pds_pkg::cfg_reg_e'(cfg_i.index))
        pds_pkg::CFG_CAMERA_X:   cam_x_q <= cfg_i.data[pds_pkg::CoordW-1:0];
        pds_pkg::CFG_CAMERA_Y:   cam_y_q <= cfg_i.data[pds_pkg::CoordW-1:0];
        pds_pkg::CFG_CAMERA_Z:   cam_z_q <= cfg_i.data[pds_pkg::CoordW-1:0];
        pds_pkg::CFG_NEAR_LIMIT: near_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign item_i.ready = (state_q == pds_pkg::ST_FILL);
  assign in_acc       = item_i.valid && item_i.ready;
  assign store        = (cnt_q < CntW'(MaxParticles));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc) begin
      if (item_i.last) begin
        cnt_q <= '0;
      end else if (store) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  pds_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_acc),
    .store_i (store),
    .last_i  (item_i.last),
    .id_i    (item_i.particle_id),
    .alive_i (item_i.exists),
    .pos_x_i (item_i.pos_x),
    .pos_y_i (item_i.pos_y),
    .pos_z_i (item_i.pos_z),
    .cam_x_i (cam_x_q),
    .cam_y_i (cam_y_q),
    .cam_z_i (cam_z_q),
    .ins_o   (ins)
  );

  for (genvar g = 0; g < MaxParticles; g++) begin : g_cell
    pds_pkg::link_t left, right;

    if (g == 0) begin : g_head
      always_comb begin
        left       = '0;
        left.valid = 1'b1;
      end
    end else begin : g_mid
      assign left = link[g-1];
    end

    if (g == MaxParticles - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = link[g+1];
    end

    pds_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ins_i   (ins),
      .shift_i (shift),
      .left_i  (left),
      .right_i (right),
      .link_o  (link[g])
    );
  end

  assign tail_empty = !link[1].valid;

  assign result_o.valid      = (state_q == pds_pkg::ST_DRAIN) && link[0].valid;
  assign result_o.out_id     = link[0].rec.id;
  assign result_o.out_exists = link[0].rec.alive;
  assign result_o.distance   = link[0].rec.depth;
  assign result_o.near       = link[0].rec.depth < {near_limit_q, 8'd0};
  assign result_o.out_last   = tail_empty;
  assign shift               = result_o.valid && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pds_pkg::ST_FILL;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pds_pkg::ST_FILL: begin
        if (in_acc && item_i.last) begin
          state_d = pds_pkg::ST_FLUSH;
        end
      end
      pds_pkg::ST_FLUSH: begin
        if (ins.valid && ins.last) begin
          state_d = pds_pkg::ST_DRAIN;
        end
      end
      pds_pkg::ST_DRAIN: begin
        if (shift && tail_empty) begin
          state_d = pds_pkg::ST_FILL;
        end
      end
      default: state_d = pds_pkg::ST_FILL;
    endcase
  end

endmodule

`default_nettype wire
